### rtl/slpa_pkg.sv
// Shared types and constants of the slot pool allocator.
package slpa_pkg;

  // Default pool size and fixed field widths of the item ports
  localparam int unsigned SLPA_POOL_SLOTS_DEF = 64;
  localparam int unsigned SLOT_INDEX_W        = 12;
  localparam int unsigned GRANT_W             = 6;
  localparam int unsigned COUNT_W             = 7;

  // Command codes
  typedef enum logic [1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_CLEAR   = 2'd2
  } slpa_cmd_e;

  // Result status codes
  typedef enum logic [2:0] {
    ST_ALLOCATED = 3'd0,
    ST_EXHAUSTED = 3'd1,
    ST_RELEASED  = 3'd2,
    ST_RANGE     = 3'd3,
    ST_NOT_USED  = 3'd4,
    ST_CLEARED   = 3'd5
  } slpa_status_e;

  // One result item
  typedef struct packed {
    slpa_status_e         status;
    logic [GRANT_W-1:0]   granted;
    logic [COUNT_W-1:0]   used;
    logic [COUNT_W-1:0]   avail;
  } slpa_res_t;

  // Free stack commands from the controller
  typedef struct packed {
    logic pop;
    logic push;
    logic clear;
  } slpa_fs_ctl_t;

endpackage

### rtl/slpa_free_stack.sv
// Free slot stack: one RAM plus a top pointer and a low-water mark.
module slpa_free_stack import slpa_pkg::*; #(
  parameter int unsigned POOL_SLOTS = SLPA_POOL_SLOTS_DEF,
  localparam int unsigned SlotW = $clog2(POOL_SLOTS),
  localparam int unsigned CntW  = $clog2(POOL_SLOTS + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  slpa_fs_ctl_t     ctl_i,
  input  logic [SlotW-1:0] push_slot_i,
  output logic [SlotW-1:0] pop_slot_o
);

  logic [SlotW-1:0] mem_q [POOL_SLOTS];
  logic [CntW-1:0]  top_q, top_d;
  logic [CntW-1:0]  min_q, min_d;
  logic [SlotW-1:0] rd_q;
  logic [SlotW-1:0] ident_q;
  logic             ident_sel_q;
  logic [SlotW-1:0] pop_addr;
  logic [SlotW-1:0] push_addr;
  logic             untouched;

  // Entries below the lowest top seen since clear were never popped, so
  // they still hold their own index and the RAM copy is not consulted.
  assign pop_addr  = SlotW'(top_q - CntW'(1));
  assign push_addr = top_q[SlotW-1:0];
  assign untouched = (top_q <= min_q);

  // Pointer and low-water mark
  always_comb begin
    top_d = top_q;
    min_d = min_q;
    if (ctl_i.clear) begin
      top_d = CntW'(POOL_SLOTS);
      min_d = CntW'(POOL_SLOTS);
    end else if (ctl_i.pop) begin
      top_d = top_q - CntW'(1);
      if (untouched) min_d = top_q - CntW'(1);
    end else if (ctl_i.push) begin
      top_d = top_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q <= CntW'(POOL_SLOTS);
      min_q <= CntW'(POOL_SLOTS);
    end else begin
      top_q <= top_d;
      min_q <= min_d;
    end
  end

  // Stack RAM, registered read
  always_ff @(posedge clk_i) begin
    if (ctl_i.push) mem_q[push_addr] <= push_slot_i;
    if (ctl_i.pop) begin
      rd_q        <= mem_q[pop_addr];
      ident_q     <= pop_addr;
      ident_sel_q <= untouched;
    end
  end

  assign pop_slot_o = ident_sel_q ? ident_q : rd_q;

endmodule

### rtl/slpa_used_list.sv
// In-use slot list RAM, one write and one registered read per cycle.
module slpa_used_list import slpa_pkg::*; #(
  parameter int unsigned POOL_SLOTS = SLPA_POOL_SLOTS_DEF,
  localparam int unsigned SlotW = $clog2(POOL_SLOTS)
) (
  input  logic             clk_i,
  input  logic             rd_en_i,
  input  logic [SlotW-1:0] rd_addr_i,
  output logic [SlotW-1:0] rd_data_o,
  input  logic             wr_en_i,
  input  logic [SlotW-1:0] wr_addr_i,
  input  logic [SlotW-1:0] wr_data_i
);

  logic [SlotW-1:0] mem_q [POOL_SLOTS];
  logic [SlotW-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) mem_q[wr_addr_i] <= wr_data_i;
    if (rd_en_i) rd_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_q;

endmodule

### rtl/slpa_ctrl.sv
// Command sequencer: allocate, search and swap-remove, clear.
module slpa_ctrl import slpa_pkg::*; #(
  parameter int unsigned POOL_SLOTS = SLPA_POOL_SLOTS_DEF,
  localparam int unsigned SlotW = $clog2(POOL_SLOTS),
  localparam int unsigned CntW  = $clog2(POOL_SLOTS + 1)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [1:0]              command_i,
  input  logic [SLOT_INDEX_W-1:0] slot_index_i,
  output logic                    res_valid_o,
  input  logic                    res_ready_i,
  output slpa_res_t               res_o,
  output slpa_fs_ctl_t            fs_ctl_o,
  output logic [SlotW-1:0]        fs_push_slot_o,
  input  logic [SlotW-1:0]        fs_pop_slot_i,
  output logic                    ul_rd_en_o,
  output logic [SlotW-1:0]        ul_rd_addr_o,
  input  logic [SlotW-1:0]        ul_rd_data_i,
  output logic                    ul_wr_en_o,
  output logic [SlotW-1:0]        ul_wr_addr_o,
  output logic [SlotW-1:0]        ul_wr_data_o
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_ALLOC  = 5'b00010,
    S_SEARCH = 5'b00100,
    S_MOVE   = 5'b01000,
    S_DONE   = 5'b10000
  } state_e;

  state_e           state_q, state_d;
  logic [SlotW-1:0] slot_q, slot_d;
  logic [SlotW-1:0] idx_q, idx_d;
  logic [CntW-1:0]  used_q, used_d;
  slpa_res_t        res_q, res_d;
  logic [SlotW-1:0] last_idx;
  logic             out_of_range;

  function automatic slpa_res_t pack_res(input slpa_status_e st,
                                         input logic [SlotW-1:0] g,
                                         input logic [CntW-1:0] u);
    slpa_res_t r;
    r.status  = st;
    r.granted = GRANT_W'(g);
    r.used    = COUNT_W'(u);
    r.avail   = COUNT_W'(CntW'(POOL_SLOTS) - u);
    return r;
  endfunction

  assign last_idx     = SlotW'(used_q - CntW'(1));
  assign out_of_range = ({1'b0, slot_index_i} >= (SLOT_INDEX_W + 1)'(POOL_SLOTS));

  always_comb begin
    state_d        = state_q;
    slot_d         = slot_q;
    idx_d          = idx_q;
    used_d         = used_q;
    res_d          = res_q;
    fs_ctl_o       = '0;
    fs_push_slot_o = slot_q;
    ul_rd_en_o     = 1'b0;
    ul_rd_addr_o   = idx_q;
    ul_wr_en_o     = 1'b0;
    ul_wr_addr_o   = idx_q;
    ul_wr_data_o   = ul_rd_data_i;

    unique case (state_q)
      // Take an item and settle the quick cases at once
      S_IDLE: begin
        if (in_valid_i) begin
          slot_d = slot_index_i[SlotW-1:0];
          state_d = S_DONE;
          unique case (command_i)
            CMD_ALLOC: begin
              if (used_q == CntW'(POOL_SLOTS)) begin
                res_d = pack_res(ST_EXHAUSTED, '0, used_q);
              end else begin
                fs_ctl_o.pop = 1'b1;
                state_d      = S_ALLOC;
              end
            end
            CMD_RELEASE: begin
              if (out_of_range) begin
                res_d = pack_res(ST_RANGE, '0, used_q);
              end else if (used_q == '0) begin
                res_d = pack_res(ST_NOT_USED, '0, used_q);
              end else begin
                ul_rd_en_o   = 1'b1;
                ul_rd_addr_o = '0;
                idx_d        = '0;
                state_d      = S_SEARCH;
              end
            end
            CMD_CLEAR: begin
              fs_ctl_o.clear = 1'b1;
              used_d         = '0;
              res_d          = pack_res(ST_CLEARED, '0, '0);
            end
            default: res_d = pack_res(ST_RANGE, '0, used_q);
          endcase
        end
      end
      // Popped slot is in; append it to the in-use list
      S_ALLOC: begin
        ul_wr_en_o   = 1'b1;
        ul_wr_addr_o = used_q[SlotW-1:0];
        ul_wr_data_o = fs_pop_slot_i;
        used_d       = used_q + CntW'(1);
        res_d        = pack_res(ST_ALLOCATED, fs_pop_slot_i, used_d);
        state_d      = S_DONE;
      end
      // One list entry compared per cycle, next read already issued
      S_SEARCH: begin
        if (ul_rd_data_i == slot_q) begin
          ul_rd_en_o   = 1'b1;
          ul_rd_addr_o = last_idx;
          state_d      = S_MOVE;
        end else if (idx_q == last_idx) begin
          res_d   = pack_res(ST_NOT_USED, '0, used_q);
          state_d = S_DONE;
        end else begin
          ul_rd_en_o   = 1'b1;
          ul_rd_addr_o = idx_q + SlotW'(1);
          idx_d        = idx_q + SlotW'(1);
        end
      end
      // Last entry fills the hole, slot goes back on the free stack
      S_MOVE: begin
        ul_wr_en_o    = 1'b1;
        ul_wr_addr_o  = idx_q;
        ul_wr_data_o  = ul_rd_data_i;
        fs_ctl_o.push = 1'b1;
        used_d        = used_q - CntW'(1);
        res_d         = pack_res(ST_RELEASED, '0, used_d);
        state_d       = S_DONE;
      end
      S_DONE: begin
        if (res_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      used_q  <= '0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
    idx_q  <= idx_d;
    res_q  <= res_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign res_valid_o = (state_q == S_DONE);
  assign res_o       = res_q;

endmodule

### rtl/slot_pool_allocator.sv
// Slot pool allocator top level: sequencer, two RAMs and the output register.
//
// Usage: one input channel carries commands (allocate, release a slot, clear
// the pool); every accepted item produces exactly one result item on the
// output channel with a status, the granted slot and the in-use and free
// counts after the command. Both channels use valid/stall handshaking.
// Clear and rejected commands are settled in the sequencer as they are
// accepted; allocate first pops the free stack and appends the slot.
// Release walks the in-use list RAM one entry per cycle until it finds the
// slot, then moves the last entry into the hole; a release of a slot not
// in use walks the whole list.
// One item is in flight at a time; the next item is accepted once the
// result has moved into the output register, even while that result waits.
// Reset: pool is full with the identity free order, in-use list empty; the
// block is ready right away, no clearing pass runs.
// A stalled output holds its result; the sequencer then waits with the next
// result and stalls the input.
module slot_pool_allocator import slpa_pkg::*; #(
  parameter int unsigned POOL_SLOTS = SLPA_POOL_SLOTS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [1:0]              command_i,
  input  logic [SLOT_INDEX_W-1:0] slot_index_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [2:0]              status_o,
  output logic [GRANT_W-1:0]      granted_slot_o,
  output logic [COUNT_W-1:0]      used_count_o,
  output logic [COUNT_W-1:0]      available_count_o
);

  localparam int unsigned SlotW = $clog2(POOL_SLOTS);

  slpa_fs_ctl_t     fs_ctl;
  logic [SlotW-1:0] fs_push_slot;
  logic [SlotW-1:0] fs_pop_slot;
  logic             ul_rd_en;
  logic [SlotW-1:0] ul_rd_addr;
  logic [SlotW-1:0] ul_rd_data;
  logic             ul_wr_en;
  logic [SlotW-1:0] ul_wr_addr;
  logic [SlotW-1:0] ul_wr_data;
  logic             res_valid;
  logic             res_load;
  slpa_res_t        res;
  logic             out_valid_q, out_valid_d;
  slpa_res_t        out_q;

  slpa_ctrl #(.POOL_SLOTS(POOL_SLOTS)) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .command_i      (command_i),
    .slot_index_i   (slot_index_i),
    .res_valid_o    (res_valid),
    .res_ready_i    (res_load),
    .res_o          (res),
    .fs_ctl_o       (fs_ctl),
    .fs_push_slot_o (fs_push_slot),
    .fs_pop_slot_i  (fs_pop_slot),
    .ul_rd_en_o     (ul_rd_en),
    .ul_rd_addr_o   (ul_rd_addr),
    .ul_rd_data_i   (ul_rd_data),
    .ul_wr_en_o     (ul_wr_en),
    .ul_wr_addr_o   (ul_wr_addr),
    .ul_wr_data_o   (ul_wr_data)
  );

  slpa_free_stack #(.POOL_SLOTS(POOL_SLOTS)) u_free_stack (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (fs_ctl),
    .push_slot_i (fs_push_slot),
    .pop_slot_o  (fs_pop_slot)
  );

  slpa_used_list #(.POOL_SLOTS(POOL_SLOTS)) u_used_list (
    .clk_i     (clk_i),
    .rd_en_i   (ul_rd_en),
    .rd_addr_i (ul_rd_addr),
    .rd_data_o (ul_rd_data),
    .wr_en_i   (ul_wr_en),
    .wr_addr_i (ul_wr_addr),
    .wr_data_i (ul_wr_data)
  );

  // Output register: loads when empty or being drained this cycle
  assign res_load    = res_valid && (!out_valid_q || !out_stall_i);
  assign out_valid_d = res_load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) out_q <= res;
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = out_q.status;
  assign granted_slot_o    = out_q.granted;
  assign used_count_o      = out_q.used;
  assign available_count_o = out_q.avail;

endmodule

### rtl/slpa_check.sv
// Port-level assertions for the slot pool allocator, bound to the top level.
module slpa_check import slpa_pkg::*; #(
  parameter int unsigned POOL_SLOTS = SLPA_POOL_SLOTS_DEF
) (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_stall_o,
  input logic                    out_valid_o,
  input logic                    out_stall_i,
  input logic [2:0]              status_o,
  input logic [GRANT_W-1:0]      granted_slot_o,
  input logic [COUNT_W-1:0]      used_count_o,
  input logic [COUNT_W-1:0]      available_count_o
);

  // One item in flight: an accepted item stalls the input next cycle
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after accepting an item");

  // A stalled result item holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o)
      && $stable(granted_slot_o) && $stable(used_count_o))
    else $error("stalled result item changed");

  // Used and free counts always add up to the pool size
  a_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> COUNT_W'(used_count_o + available_count_o) == COUNT_W'(POOL_SLOTS))
    else $error("used and free counts disagree with pool size");

  // Only a successful allocate grants a nonzero slot
  a_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_ALLOCATED) |-> granted_slot_o == '0)
    else $error("slot granted without allocation");

  // Clear leaves nothing in use; exhaustion means nothing free
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((status_o == ST_CLEARED) || (status_o == ST_EXHAUSTED))
      |-> ((status_o == ST_CLEARED) ? (used_count_o == '0) : (available_count_o == '0)))
    else $error("count wrong after clear or exhaustion");

endmodule

bind slot_pool_allocator slpa_check #(.POOL_SLOTS(POOL_SLOTS)) u_slpa_check (.*);

### verif/tb_slot_pool_allocator.sv
// Self-checking testbench for the slot pool allocator: directed table, random traffic.
module tb_slot_pool_allocator;
  import slpa_pkg::*;

  localparam int unsigned POOL       = SLPA_POOL_SLOTS_DEF;
  localparam logic [1:0]  CMD_SPARE  = 2'd3;  // unused command code
  localparam int          RAND_ITEMS = 520;
  localparam int          LONG_HOLD  = 300;
  localparam int          DRAIN_WAIT = 80;    // longer than the slowest release

  // Clock, reset and block ports
  logic                    clk_i             = 1'b0;
  logic                    rst_ni            = 1'b0;
  logic                    in_valid_i        = 1'b0;
  logic                    in_stall_o;
  logic [1:0]              command_i         = CMD_ALLOC;
  logic [SLOT_INDEX_W-1:0] slot_index_i      = '0;
  logic                    out_valid_o;
  logic                    out_stall_i       = 1'b0;
  logic [2:0]              status_o;
  logic [GRANT_W-1:0]      granted_slot_o;
  logic [COUNT_W-1:0]      used_count_o;
  logic [COUNT_W-1:0]      available_count_o;

  slot_pool_allocator dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .command_i         (command_i),
    .slot_index_i      (slot_index_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .status_o          (status_o),
    .granted_slot_o    (granted_slot_o),
    .used_count_o      (used_count_o),
    .available_count_o (available_count_o)
  );

  // Directed table row
  typedef struct {
    logic [1:0]              cmd;
    logic [SLOT_INDEX_W-1:0] slot;
    int                      reps;
    bit                      typed;
    slpa_res_t               res;
  } script_row_t;

  // Shadow copy of the pool
  logic [GRANT_W-1:0] free_stk [POOL];
  logic [GRANT_W-1:0] busy_list[POOL];
  int unsigned        free_cnt;
  int unsigned        busy_cnt;

  slpa_res_t   pending_results[$];
  script_row_t script[$];
  int          mismatches = 0;
  bit          steady     = 1'b0;  // no idling on either side
  bit          hold_req   = 1'b0;  // receiver holds off for a long stretch

  // Clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Run limit
  initial begin
    #5000000;
    $display("CHECK FAILED");
    $finish;
  end

  // Pool state after reset or clear
  task automatic pool_restore();
    for (int i = 0; i < POOL; i++) free_stk[i] = GRANT_W'(i);
    free_cnt = POOL;
    busy_cnt = 0;
  endtask

  // Apply one command to the shadow pool and return the expected result
  function automatic slpa_res_t pool_apply(logic [1:0] cmd, logic [SLOT_INDEX_W-1:0] slot);
    slpa_res_t r;
    int        pos;
    bit        hit;
    r.status  = ST_RANGE;
    r.granted = '0;
    pos       = 0;
    hit       = 1'b0;
    case (cmd)
      CMD_ALLOC: begin
        if (free_cnt == 0 || busy_cnt >= POOL) begin
          r.status = ST_EXHAUSTED;
        end else begin
          free_cnt--;
          r.granted           = free_stk[free_cnt];
          busy_list[busy_cnt] = r.granted;
          busy_cnt++;
          r.status = ST_ALLOCATED;
        end
      end
      CMD_RELEASE: begin
        if (slot < POOL) begin
          for (int i = 0; i < busy_cnt; i++) begin
            if (!hit && busy_list[i] == slot[GRANT_W-1:0]) begin
              hit = 1'b1;
              pos = i;
            end
          end
          if (hit && free_cnt < POOL) begin
            // swap-remove from the in-use list, push on the free stack
            busy_cnt--;
            busy_list[pos]     = busy_list[busy_cnt];
            free_stk[free_cnt] = slot[GRANT_W-1:0];
            free_cnt++;
            r.status = ST_RELEASED;
          end else begin
            r.status = ST_NOT_USED;
          end
        end
      end
      CMD_CLEAR: begin
        for (int i = 0; i < POOL; i++) free_stk[i] = GRANT_W'(i);
        free_cnt = POOL;
        busy_cnt = 0;
        r.status = ST_CLEARED;
      end
      default: ;
    endcase
    r.used  = COUNT_W'(busy_cnt);
    r.avail = COUNT_W'(free_cnt);
    return r;
  endfunction

  task automatic plan(logic [1:0] cmd, logic [SLOT_INDEX_W-1:0] slot, int reps, bit typed,
                      slpa_status_e st, int g, int u, int a);
    script_row_t row;
    row.cmd         = cmd;
    row.slot        = slot;
    row.reps        = reps;
    row.typed       = typed;
    row.res.status  = st;
    row.res.granted = GRANT_W'(g);
    row.res.used    = COUNT_W'(u);
    row.res.avail   = COUNT_W'(a);
    script.push_back(row);
  endtask

  // Offer one item, wait for it to be taken, record its expected result
  task automatic send_item(logic [1:0] cmd, logic [SLOT_INDEX_W-1:0] slot, bit typed,
                           slpa_res_t typed_res);
    int        gap;
    slpa_res_t pr;
    gap = steady ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    command_i    <= cmd;
    slot_index_i <= slot;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    pr = pool_apply(cmd, slot);
    pending_results.push_back(typed ? typed_res : pr);
  endtask

  task automatic flag_mismatch(string field, int got, int want);
    $display("%0t: mismatch on %s: got %0d, want %0d", $time, field, got, want);
    mismatches++;
  endtask

  // Sender: reset, directed table, then random traffic
  initial begin
    slpa_res_t               none;
    logic [1:0]              cmd;
    logic [SLOT_INDEX_W-1:0] slot;
    int                      r;
    bit                      fill;
    none = '{ST_ALLOCATED, '0, '0, '0};
    pool_restore();

    // after reset: allocate pops slot 63, rejects leave counts alone
    plan(CMD_ALLOC,   12'd0,    1, 1'b1, ST_ALLOCATED, 63, 1, 63);
    plan(CMD_RELEASE, 12'hFFF,  1, 1'b1, ST_RANGE,      0, 1, 63);
    plan(CMD_RELEASE, 12'd64,   1, 1'b1, ST_RANGE,      0, 1, 63);
    plan(CMD_RELEASE, 12'd0,    1, 1'b1, ST_NOT_USED,   0, 1, 63);
    plan(CMD_SPARE,   12'hAAA,  1, 1'b1, ST_RANGE,      0, 1, 63);
    plan(CMD_RELEASE, 12'd63,   1, 1'b1, ST_RELEASED,   0, 0, 64);
    // double release is rejected
    plan(CMD_RELEASE, 12'd63,   1, 1'b1, ST_NOT_USED,   0, 0, 64);
    plan(CMD_ALLOC,   12'h555,  1, 1'b1, ST_ALLOCATED, 63, 1, 63);
    plan(CMD_ALLOC,   12'd0,    1, 1'b1, ST_ALLOCATED, 62, 2, 62);
    plan(CMD_ALLOC,   12'd0,    1, 1'b0, ST_ALLOCATED,  0, 0, 0);
    // release from the head of the in-use list, then the entry the swap moved there
    plan(CMD_RELEASE, 12'd63,   1, 1'b0, ST_ALLOCATED,  0, 0, 0);
    plan(CMD_RELEASE, 12'd61,   1, 1'b0, ST_ALLOCATED,  0, 0, 0);
    // fill the pool, then run dry
    plan(CMD_ALLOC,   12'd0,   63, 1'b0, ST_ALLOCATED,  0, 0, 0);
    plan(CMD_ALLOC,   12'hFFF,  1, 1'b1, ST_EXHAUSTED,  0, 64, 0);
    plan(CMD_RELEASE, 12'hFFF,  1, 1'b1, ST_RANGE,      0, 64, 0);
    plan(CMD_RELEASE, 12'd0,    1, 1'b1, ST_RELEASED,   0, 63, 1);
    plan(CMD_ALLOC,   12'd0,    1, 1'b1, ST_ALLOCATED,  0, 64, 0);
    plan(CMD_CLEAR,   12'hFFF,  1, 1'b1, ST_CLEARED,    0, 0, 64);
    plan(CMD_RELEASE, 12'h555,  1, 1'b1, ST_RANGE,      0, 0, 64);
    plan(CMD_RELEASE, 12'd42,   1, 1'b1, ST_NOT_USED,   0, 0, 64);
    plan(CMD_SPARE,   12'd0,    1, 1'b1, ST_RANGE,      0, 0, 64);
    plan(CMD_CLEAR,   12'd0,    1, 1'b1, ST_CLEARED,    0, 0, 64);
    plan(CMD_ALLOC,   12'd0,    1, 1'b1, ST_ALLOCATED, 63, 1, 63);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (script[k]) begin
      for (int j = 0; j < script[k].reps; j++) begin
        send_item(script[k].cmd, script[k].slot, script[k].typed, script[k].res);
      end
    end

    // random traffic in alternating fill and drain phases
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n == 150) hold_req = 1'b1;
      if (n == 300) begin
        // pause the sender until every result is back
        in_valid_i <= 1'b0;
        wait (pending_results.size() == 0);
      end
      steady = (n >= 400 && n < 460);
      fill   = ((n / 120) % 2) == 0;
      r      = $urandom_range(0, 99);
      slot   = SLOT_INDEX_W'($urandom_range(0, 4095));
      if (r < (fill ? 72 : 25)) begin
        cmd = CMD_ALLOC;
      end else if (r < 88) begin
        // release of a slot taken from the in-use list
        cmd = CMD_RELEASE;
        if (busy_cnt > 0) slot = SLOT_INDEX_W'(busy_list[$urandom_range(0, busy_cnt - 1)]);
        else slot = SLOT_INDEX_W'($urandom_range(0, POOL - 1));
      end else if (r < 89) begin
        cmd = CMD_CLEAR;
      end else if (r < 91) begin
        cmd = CMD_SPARE;
      end else if (r < 95) begin
        cmd  = CMD_RELEASE;
        slot = SLOT_INDEX_W'($urandom_range(POOL, 4095));
      end else begin
        cmd  = CMD_RELEASE;
        slot = SLOT_INDEX_W'($urandom_range(0, POOL - 1));
      end
      send_item(cmd, slot, 1'b0, none);
    end
    in_valid_i <= 1'b0;

    wait (pending_results.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Receiver: random stalls, one long hold-off, field-by-field check
  initial begin
    int        n;
    slpa_res_t want;
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_req) begin
        n        = LONG_HOLD;
        hold_req = 1'b0;
      end else begin
        n = steady ? 0 : $urandom_range(0, 7);
      end
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (out_valid_o !== 1'b1);
      if (pending_results.size() == 0) begin
        flag_mismatch("unexpected item", status_o, 0);
      end else begin
        want = pending_results.pop_front();
        if (status_o !== want.status) flag_mismatch("status", status_o, want.status);
        if (granted_slot_o !== want.granted)
          flag_mismatch("granted_slot", granted_slot_o, want.granted);
        if (used_count_o !== want.used) flag_mismatch("used_count", used_count_o, want.used);
        if (available_count_o !== want.avail)
          flag_mismatch("available_count", available_count_o, want.avail);
      end
    end
  end

endmodule

### filelist.f
rtl/slpa_pkg.sv
rtl/slpa_free_stack.sv
rtl/slpa_used_list.sv
rtl/slpa_ctrl.sv
rtl/slot_pool_allocator.sv
rtl/slpa_check.sv
verif/tb_slot_pool_allocator.sv
